FILE: sv/sct_pkg.sv
// shared types, constants and codes of the scoped category table
// no dependencies
package sct_pkg;

	localparam int CHAR_W = 8;
	localparam int CHARS  = 1 << CHAR_W;
	localparam int LVL_W  = 3;
	localparam int LEVELS = 1 << LVL_W;
	localparam int CAT_W  = 4;
	localparam int OP_W   = 3;
	localparam int STAT_W = 2;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [LVL_W-1:0] LVL_MAX = LVL_W'(LEVELS - 1);
	localparam logic [CHAR_W-1:0] CHAR_MAX = CHAR_W'(CHARS - 1);

	localparam logic [CAT_W-1:0] DEFAULT_CAT_RESET = CAT_W'(12);

	// register index of default_category
	localparam logic [PADDR_W-3:0] REG_DEFAULT_CAT = '0;

	// operation codes
	localparam logic [OP_W-1:0] OP_GET   = 3'd0;
	localparam logic [OP_W-1:0] OP_SET   = 3'd1;
	localparam logic [OP_W-1:0] OP_PUSH  = 3'd2;
	localparam logic [OP_W-1:0] OP_POP   = 3'd3;
	localparam logic [OP_W-1:0] OP_RESET = 3'd4;

	// status codes
	localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
	localparam logic [STAT_W-1:0] ST_REFUSED = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]   operation;
		logic [CHAR_W-1:0] first_char;
		logic [CHAR_W-1:0] last_char;
		logic [CAT_W-1:0]  new_category;
		logic              protect_flag;
		logic [LVL_W-1:0]  start_level;
	} sct_in_t;

	typedef struct packed {
		logic [CAT_W-1:0]  category_out;
		logic [STAT_W-1:0] status;
		logic [LVL_W-1:0]  current_level;
	} sct_out_t;

	// one table row: a valid bit and a category per level
	typedef struct packed {
		logic [LEVELS-1:0]            valid;
		logic [LEVELS-1:0][CAT_W-1:0] cat;
	} sct_entry_t;

	typedef struct packed {
		logic              re;
		logic [CHAR_W-1:0] raddr;
		logic              we;
		logic [CHAR_W-1:0] waddr;
		sct_entry_t        wdata;
	} sct_mem_req_t;

endpackage

FILE: sv/sct_store.sv
// row store of the scoped category table: one synchronous memory with a registered read
// row-written flags make never-written rows read with all valid bits clear; uses sct_pkg
module sct_store import sct_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  sct_mem_req_t req,
	output sct_entry_t   rdata
);

	sct_entry_t mem_q [CHARS];
	logic       row_written_q [CHARS];
	sct_entry_t raw_s1;
	logic       row_ok_s1;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			raw_s1 <= mem_q[req.raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHARS; i++) begin
				row_written_q[i] <= 1'b0;
			end
			row_ok_s1 <= 1'b0;
		end else begin
			if (req.we) begin
				row_written_q[req.waddr] <= 1'b1;
			end
			if (req.re) begin
				row_ok_s1 <= row_written_q[req.raddr];
			end
		end
	end

	always_comb begin
		rdata = raw_s1;
		if (!row_ok_s1) begin
			rdata.valid = '0;
		end
	end

endmodule

FILE: sv/sct_seq.sv
// sequencer of the scoped category table: level state and read-modify-write row sweeps
// drives the row store request; uses sct_pkg
module sct_seq import sct_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  sct_in_t           in_data,
	input  logic [CAT_W-1:0]  default_cat,
	input  logic              out_free,
	output logic              done,
	output sct_out_t          result,
	output sct_mem_req_t      mem_req,
	input  sct_entry_t        mem_rdata
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_GET   = 5'b00010,
		S_SWEEP = 5'b00100,
		S_DRAIN = 5'b01000,
		S_FIN   = 5'b10000
	} state_t;

	state_t            state_q;
	logic [OP_W-1:0]   op_q;
	logic [CAT_W-1:0]  new_cat_q;
	logic [CHAR_W-1:0] cnt_q;
	logic [CHAR_W-1:0] end_q;
	logic [LVL_W-1:0]  level_q;
	logic [LVL_W-1:0]  mark_q;
	logic [STAT_W-1:0] status_q;
	logic [CAT_W-1:0]  cat_out_q;
	logic              rd_s1;
	logic [CHAR_W-1:0] addr_s1;

	sct_entry_t        new_row;
	logic [CAT_W-1:0]  get_cat;
	logic [LVL_W-1:0]  start_sat;

	assign in_ready = (state_q == S_IDLE);
	assign start_sat = (in_data.start_level > LVL_MAX) ? LVL_MAX : in_data.start_level;

	// highest valid level wins
	always_comb begin
		get_cat = default_cat;
		for (int l = 0; l < LEVELS; l++) begin
			if (mem_rdata.valid[l]) begin
				get_cat = mem_rdata.cat[l];
			end
		end
	end

	// row update for the sweeping operations
	always_comb begin
		new_row = mem_rdata;
		case (op_q)
			OP_SET: begin
				if (new_cat_q == default_cat && level_q == '0) begin
					new_row.valid = '0;
				end else begin
					new_row.valid[level_q] = 1'b1;
					new_row.cat[level_q] = new_cat_q;
				end
			end
			OP_POP: begin
				new_row.valid[level_q] = 1'b0;
			end
			OP_RESET: begin
				for (int l = 0; l < LEVELS; l++) begin
					if (LVL_W'(l) > level_q) begin
						new_row.valid[l] = 1'b0;
					end
				end
			end
			default: begin
				new_row = mem_rdata;
			end
		endcase
	end

	always_comb begin
		mem_req.re = 1'b0;
		mem_req.raddr = cnt_q;
		mem_req.we = rd_s1;
		mem_req.waddr = addr_s1;
		mem_req.wdata = new_row;
		if (state_q == S_IDLE && in_valid && in_data.operation == OP_GET) begin
			mem_req.re = 1'b1;
			mem_req.raddr = in_data.first_char;
		end else if (state_q == S_SWEEP) begin
			mem_req.re = 1'b1;
		end
	end

	assign done = (state_q == S_FIN) && out_free;
	assign result.category_out = cat_out_q;
	assign result.status = status_q;
	assign result.current_level = level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			level_q <= '0;
			mark_q <= '0;
			rd_s1 <= 1'b0;
		end else begin
			rd_s1 <= (state_q == S_SWEEP);
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						case (in_data.operation)
							OP_GET: begin
								state_q <= S_GET;
							end
							OP_SET: begin
								state_q <= (in_data.first_char <= in_data.last_char) ?
									S_SWEEP : S_FIN;
							end
							OP_PUSH: begin
								if (level_q != LVL_MAX) begin
									level_q <= level_q + 1'b1;
									if (in_data.protect_flag) begin
										mark_q <= level_q + 1'b1;
									end
								end
								state_q <= S_FIN;
							end
							OP_POP: begin
								state_q <= (level_q > mark_q) ? S_SWEEP : S_FIN;
							end
							OP_RESET: begin
								level_q <= start_sat;
								mark_q <= start_sat;
								state_q <= S_SWEEP;
							end
							default: begin
								state_q <= S_FIN;
							end
						endcase
					end
				end
				S_GET: begin
					state_q <= S_FIN;
				end
				S_SWEEP: begin
					if (cnt_q == end_q) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (op_q == OP_POP) begin
						level_q <= level_q - 1'b1;
					end
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// item fields and sweep bounds
	always_ff @(posedge clk) begin
		addr_s1 <= cnt_q;
		if (state_q == S_IDLE && in_valid) begin
			op_q <= in_data.operation;
			new_cat_q <= in_data.new_category;
			cat_out_q <= '0;
			status_q <= ST_DONE;
			if (in_data.operation == OP_SET) begin
				cnt_q <= in_data.first_char;
				end_q <= in_data.last_char;
			end else begin
				cnt_q <= '0;
				end_q <= CHAR_MAX;
			end
			if (in_data.operation == OP_PUSH && level_q == LVL_MAX) begin
				status_q <= ST_FULL;
			end
			if (in_data.operation == OP_POP && level_q <= mark_q) begin
				status_q <= ST_REFUSED;
			end
		end
		if (state_q == S_SWEEP && cnt_q != end_q) begin
			cnt_q <= cnt_q + 1'b1;
		end
		if (state_q == S_GET) begin
			cat_out_q <= get_cat;
		end
	end

endmodule

FILE: sv/scoped_category_table.sv
// Scoped category table: a 4-bit category for each of 256 character codes under eight nested
// scope levels, held in one 256-row memory (a row holds a valid bit and a category per level).
// One item is worked at a time; a get reads one row, while push, an empty range set, unused
// operations and a refused pop read no row and go straight to the result. A range set is a
// read-modify-write sweep over the range, one row per cycle; pop and reset sweep every row.
// The memory has a single read and a single write port; a result that waits in a full
// output register holds the sequencer until taken.
// A finished result waits in the output register while the next item is accepted.
// Depends on sct_pkg, sct_seq and sct_store.
module scoped_category_table import sct_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	// configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	// input items
	input  logic               in_valid,
	output logic               in_ready,
	input  sct_in_t            in_data,
	// result items
	output logic               out_valid,
	input  logic               out_ready,
	output sct_out_t           out_data
);

	logic [CAT_W-1:0] default_cat_q;
	logic             reg_hit;
	logic             out_valid_q;
	sct_out_t         out_q;
	logic             out_free;
	logic             done;
	sct_out_t         result;
	sct_mem_req_t     mem_req;
	sct_entry_t       mem_rdata;

	// register decode: word index above the byte offset
	assign pready = 1'b1;
	assign reg_hit = (paddr[PADDR_W-1:2] == REG_DEFAULT_CAT);
	assign prdata = reg_hit ? PDATA_W'(default_cat_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_cat_q <= DEFAULT_CAT_RESET;
		end else if (psel && penable && pwrite && reg_hit) begin
			default_cat_q <= pwdata[CAT_W-1:0];
		end
	end

	// output register, free when empty or being taken
	assign out_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			out_q <= result;
		end
	end

	// sequencer: level state and row sweeps
	sct_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.default_cat (default_cat_q),
		.out_free    (out_free),
		.done        (done),
		.result      (result),
		.mem_req     (mem_req),
		.mem_rdata   (mem_rdata)
	);

	// row memory
	sct_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mem_req),
		.rdata  (mem_rdata)
	);

`ifndef SYNTHESIS
	// one item at a time: no acceptance in the cycle after one
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("item accepted while previous item still in work");

	// a level-full result only ever reports the top level
	a_full_level: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.status == ST_FULL) |-> (out_data.current_level == LVL_MAX))
		else $error("level-full status below the top level");

	// the table is only written while an item is in work
	a_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.we |-> !in_ready)
		else $error("row write while idle");
`endif

endmodule
